>>> sv/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> sv/fpds_pkg.sv
package fpds_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_SHIFT = 14;
  localparam int Q_BITS      = FRAC_BITS + GUARD_SHIFT;

  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dsr;
    logic [Q_BITS-1:0] dq;
    logic              neg;
    logic              sat;
  } divstage_t;

  function automatic divstage_t div_step(input divstage_t s);
    logic [DATA_W:0]   sh;
    logic [DATA_W+1:0] diff;
    divstage_t         r;
    sh   = {s.rem, s.dq[Q_BITS-1]};
    diff = {1'b0, sh} - {2'b00, s.dsr};
    r    = s;
    if (!diff[DATA_W+1]) begin
      r.rem = diff[DATA_W-1:0];
    end else begin
      r.rem = sh[DATA_W-1:0];
    end
    r.dq = {s.dq[Q_BITS-2:0], ~diff[DATA_W+1]};
    return r;
  endfunction

endpackage

>>> sv/fixed_point_divide_saturating_top.sv
// Channel  Dir  tdata                                    tuser
// s_*      in   [31:0] dividend, [63:32] divisor          -
// m_*      out  [31:0] quotient                           [0] saturated
//
// Pipeline: magnitude stage, guard stage, 30 restoring divide
// stages (one quotient bit each), sign/saturation output register.
// One transfer per cycle sustained while m_tready stays high; throughput is set by the one-bit-per-stage
// divider chain, which is fully pipelined.
// rst is synchronous and clears all valid bits, including the input skid register's valid flag.
// A stall on m_tready freezes every stage; the input skid register takes one
// more transfer so s_tready is a register output.
`include "assert_macros.svh"

module fixed_point_divide_saturating_top import fpds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] dividend, [63:32] divisor
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] quotient
  output logic [0:0]  m_tuser    // [0] saturated
);

  logic                ce;
  logic                skid_valid;
  logic [63:0]         skid_data;
  logic [63:0]         in_data;
  logic [DATA_W-1:0]   in_a;
  logic [DATA_W-1:0]   in_b;

  logic                mag_vld;
  logic [DATA_W-1:0]   mag_a;
  logic [DATA_W-1:0]   mag_b;
  logic                mag_neg;

  logic      [Q_BITS:0] vld;
  divstage_t            st [Q_BITS+1];
  divstage_t            st_next [Q_BITS];

  logic [DATA_W-1:0]   q_pos;
  logic [DATA_W-1:0]   q_res;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;
  assign in_data  = skid_valid ? skid_data : s_tdata;
  assign in_a     = in_data[DATA_W-1:0];
  assign in_b     = in_data[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (ce) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
    if (!ce && s_tvalid && s_tready) begin
      skid_data <= s_tdata;
    end
  end

  // magnitudes as unsigned 32 bits; the most negative input maps to 2^31
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_vld <= 1'b0;
    end else if (ce) begin
      mag_vld <= skid_valid || (s_tvalid && s_tready);
    end
    if (ce) begin
      mag_a   <= in_a[DATA_W-1] ? (~in_a + 1'b1) : in_a;
      mag_b   <= in_b[DATA_W-1] ? (~in_b + 1'b1) : in_b;
      mag_neg <= in_a[DATA_W-1] ^ in_b[DATA_W-1];
    end
  end

  always_comb begin
    for (int k = 0; k < Q_BITS; k++) begin
      st_next[k] = div_step(st[k]);
    end
  end

  // guard stage: flag saturation when |a| >> 14 >= |b| and seed the divider;
  // advance the divider chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[Q_BITS-1:0], mag_vld};
    end
    if (ce) begin
      st[0].rem <= {{GUARD_SHIFT{1'b0}}, mag_a[DATA_W-1:GUARD_SHIFT]};
      st[0].dsr <= mag_b;
      st[0].dq  <= {mag_a[GUARD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      st[0].neg <= mag_neg;
      st[0].sat <= {{GUARD_SHIFT{1'b0}}, mag_a[DATA_W-1:GUARD_SHIFT]} >= mag_b;
      for (int k = 0; k < Q_BITS; k++) begin
        st[k+1] <= st_next[k];
      end
    end
  end

  assign q_pos = {{(DATA_W-Q_BITS){1'b0}}, st[Q_BITS].dq};

  always_comb begin
    if (st[Q_BITS].sat) begin
      q_res = st[Q_BITS].neg ? MOST_NEG : MOST_POS;
    end else if (st[Q_BITS].neg) begin
      q_res = ~q_pos + 1'b1;
    end else begin
      q_res = q_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= vld[Q_BITS];
    end
    if (ce) begin
      m_tdata    <= q_res;
      m_tuser[0] <= st[Q_BITS].sat;
    end
  end

  `ASSERT_CLK(a_sat_value,
    !(m_tvalid && m_tuser[0]) || m_tdata == MOST_NEG || m_tdata == MOST_POS,
    "saturated result is not an extreme value")
  `ASSERT_CLK(a_quot_range,
    !(m_tvalid && !m_tuser[0]) || m_tdata[31:30] == 2'b00 || m_tdata[31:30] == 2'b11,
    "unsaturated quotient out of range")
  `ASSERT_NEXT(a_stall_hold, !ce, $stable(vld) && $stable(mag_vld),
    "pipeline moved during a stall")
  `ASSERT_CLK(a_skid_fill, !$rose(skid_valid) || $past(!ce),
    "skid register filled while pipeline advanced")

endmodule
